### rtl/shc_pkg.sv
// Shared types and constants for the star HFR / centroid core.
`timescale 1ns / 1ps
`default_nettype none
package shc_pkg;

  localparam int FRAC       = 8;    // fraction bits of every fixed-point value
  localparam int PIX_W      = 16;
  localparam int COORD_W    = 24;
  localparam int FLUX_W     = 16;
  localparam int AX_W       = 18;   // offsets at or beyond 2^18 are outside any circle
  localparam int D2_W       = 37;
  localparam int OFS_W      = 17;
  localparam int TOT_W      = 28;
  localparam int WSUM_W     = 53;
  localparam int OSUM_W     = 46;
  localparam int DIST_W     = 19;
  localparam int SQ_W       = 38;   // square root operand, even
  localparam int DIV_N      = 54;
  localparam int DIV_D      = 28;
  localparam int FIFO_DEPTH = 4;
  localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_WINDOW_X   = 3'd2,
    REG_WINDOW_Y   = 3'd3,
    REG_STAR_RAD   = 3'd4,
    REG_BACKGROUND = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [PIX_W-1:0]   window_x;
    logic [PIX_W-1:0]   window_y;
    logic [PIX_W-1:0]   star_radius;
    logic [COORD_W-1:0] background_mean;
  } shc_cfg_t;

  typedef struct packed {
    logic [FLUX_W-1:0]       flux;
    logic [D2_W-1:0]         d2;
    logic signed [OFS_W-1:0] ofs_x;
    logic signed [OFS_W-1:0] ofs_y;
    logic                    in_range;
    logic                    last;
  } shc_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] half_flux_radius;
    logic [COORD_W-1:0] mean_flux;
    logic [COORD_W-1:0] centroid_x;
    logic [COORD_W-1:0] centroid_y;
    logic               centroid_updated;
  } shc_result_t;

  typedef enum logic [3:0] {
    B_IDLE, B_CHECK, B_SQRT, B_MUL, B_ACC, B_FIN, B_DIV, B_RSQRT, B_EMIT
  } back_state_t;

  typedef enum logic [2:0] {
    OP_HFR, OP_CX, OP_CY, OP_MEAN
  } div_op_t;

endpackage
`default_nettype wire

### rtl/shc_front.sv
// Front end: pixel intake, background subtraction, offsets and squared distance.
`timescale 1ns / 1ps
`default_nettype none
module shc_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [15:0]               pixel_x,
  input  wire logic [15:0]               pixel_y,
  input  wire logic [15:0]               pixel_value,
  input  wire logic                      last_pixel,
  input  wire shc_pkg::shc_cfg_t         cfg,
  input  wire logic [shc_pkg::LVL_W-1:0] fifo_level,
  output logic                           push,
  output shc_pkg::shc_item_t             push_item
);
  import shc_pkg::*;

  logic                    s1_v_r, s2_v_r;
  logic [FLUX_W-1:0]       s1_flux_r, s2_flux_r;
  logic [AX_W-1:0]         s1_ax_r, s1_ay_r;
  logic                    s1_rng_r, s2_rng_r, s1_last_r, s2_last_r;
  logic signed [OFS_W-1:0] s1_ox_r, s1_oy_r, s2_ox_r, s2_oy_r;
  logic [2*AX_W-1:0]       s2_ax2_r, s2_ay2_r;

  logic signed [25:0] diff, dx, dy;
  logic [25:0]        rnd, ax, ay;
  logic [FLUX_W-1:0]  flux;
  logic [LVL_W:0]     used;
  logic               accept;

  always_comb begin
    diff = $signed({2'b00, pixel_value, 8'h00}) - $signed({2'b00, cfg.background_mean});
    rnd  = 26'(diff) + 26'(1 << (FRAC - 1));
    flux = (diff > 0) ? rnd[FLUX_W+FRAC-1:FRAC] : '0;
    dx   = $signed({2'b00, pixel_x, 8'h00}) - $signed({2'b00, cfg.center_x});
    dy   = $signed({2'b00, pixel_y, 8'h00}) - $signed({2'b00, cfg.center_y});
    ax   = dx[25] ? 26'(-dx) : 26'(dx);
    ay   = dy[25] ? 26'(-dy) : 26'(dy);
    // count items in flight so the queue can never overflow
    used     = (LVL_W+1)'(fifo_level) + (LVL_W+1)'(s1_v_r) + (LVL_W+1)'(s2_v_r);
    in_ready = used < (LVL_W+1)'(FIFO_DEPTH);
    accept   = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
    s1_flux_r <= flux;
    s1_ax_r   <= ax[AX_W-1:0];
    s1_ay_r   <= ay[AX_W-1:0];
    s1_rng_r  <= (ax[25:AX_W] == '0) && (ay[25:AX_W] == '0);
    s1_ox_r   <= $signed({1'b0, pixel_x}) - $signed({1'b0, cfg.window_x});
    s1_oy_r   <= $signed({1'b0, pixel_y}) - $signed({1'b0, cfg.window_y});
    s1_last_r <= last_pixel;
    s2_flux_r <= s1_flux_r;
    s2_ax2_r  <= s1_ax_r * s1_ax_r;
    s2_ay2_r  <= s1_ay_r * s1_ay_r;
    s2_rng_r  <= s1_rng_r;
    s2_ox_r   <= s1_ox_r;
    s2_oy_r   <= s1_oy_r;
    s2_last_r <= s1_last_r;
  end

  assign push               = s2_v_r;
  assign push_item.flux     = s2_flux_r;
  assign push_item.d2       = {1'b0, s2_ax2_r} + {1'b0, s2_ay2_r};
  assign push_item.ofs_x    = s2_ox_r;
  assign push_item.ofs_y    = s2_oy_r;
  assign push_item.in_range = s2_rng_r;
  assign push_item.last     = s2_last_r;

endmodule
`default_nettype wire

### rtl/shc_fifo.sv
// Short item queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module shc_fifo (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire shc_pkg::shc_item_t        din,
  input  wire logic                      pop,
  output shc_pkg::shc_item_t             dout,
  output logic                           empty,
  output logic [shc_pkg::LVL_W-1:0]      level
);
  import shc_pkg::*;

  shc_item_t        mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [LVL_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + LVL_W'(push) - LVL_W'(pop);
    end
    if (push) mem_r[wr_r] <= din;
  end

  assign dout  = mem_r[rd_r];
  assign empty = (cnt_r == '0);
  assign level = cnt_r;

endmodule
`default_nettype wire

### rtl/shc_sqrt.sv
// Bit-pair iterative integer square root, floor result.
`timescale 1ns / 1ps
`default_nettype none
module shc_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [shc_pkg::SQ_W-1:0]   val,
  output logic                            done,
  output logic [shc_pkg::DIST_W-1:0]      root
);
  import shc_pkg::*;

  logic [SQ_W-1:0] v_r, res_r, bit_r, trial;
  logic            busy_r, done_r;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && bit_r[0];
      if (start)              busy_r <= 1'b1;
      else if (busy_r && bit_r[0]) busy_r <= 1'b0;
    end
    if (start) begin
      v_r   <= val;
      res_r <= '0;
      bit_r <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[DIST_W-1:0];

endmodule
`default_nettype wire

### rtl/shc_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module shc_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [shc_pkg::DIV_N-1:0]   num,
  input  wire logic [shc_pkg::DIV_D-1:0]   den,
  output logic                             done,
  output logic [shc_pkg::DIV_N-1:0]        quo
);
  import shc_pkg::*;

  localparam int CNT_W = $clog2(DIV_N);

  logic [DIV_D-1:0] rem_r, den_r;
  logic [DIV_N-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r, ge;
  logic [DIV_D:0]   shifted, diff;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_N-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = shifted >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start)                         busy_r <= 1'b1;
      else if (busy_r && (cnt_r == '0))  busy_r <= 1'b0;
    end
    if (start) begin
      quo_r <= num;
      den_r <= den;
      rem_r <= '0;
      cnt_r <= CNT_W'(DIV_N - 1);
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_D-1:0] : shifted[DIV_D-1:0];
      quo_r <= {quo_r[DIV_N-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

### rtl/shc_back.sv
// Back end: circle test, accumulation and per-star result computation.
`timescale 1ns / 1ps
`default_nettype none
module shc_back #(
  parameter int MAX_PIXELS = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire shc_pkg::shc_cfg_t  cfg,
  input  wire logic               fifo_empty,
  output logic                    fifo_pop,
  input  wire shc_pkg::shc_item_t fifo_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output shc_pkg::shc_result_t    out_res
);
  import shc_pkg::*;

  localparam int SEEN_W = $clog2(MAX_PIXELS + 1);
  localparam logic [COORD_W-1:0] MAX24 = '1;
  // ceil(2^21 / 25): exact floor(r / 25) for any 16-bit r
  localparam logic [32:0] RAD_RECIP = 33'd83887;

  back_state_t state_r, state_nxt;
  div_op_t     op_r, op_nxt;

  shc_item_t               item_r;
  logic                    counted_r, upd_r, out_valid_r;
  logic [SEEN_W-1:0]       seen_r;
  logic [TOT_W-1:0]        total_r, cf_r;
  logic [WSUM_W-1:0]       wsum_r;
  logic signed [OSUM_W-1:0] sx_r, sy_r;
  logic [31:0]             r2_r;
  logic [DIST_W-1:0]       dist_r;
  logic [FLUX_W+DIST_W-1:0] pd_r;
  logic signed [2*OFS_W-1:0] px_r, py_r;
  logic [COORD_W-1:0]      hfr_r, cxo_r, cyo_r, mean_r;
  shc_result_t             out_res_r;
  logic [PIX_W-1:0]        rad_r;
  logic [11:0]             rad_q_r, rad_q2_r;
  logic [4:0]              rad_s_r;
  logic [23:0]             rad_qq_r;
  logic [16:0]             rad_qs_r;
  logic [10:0]             rad_t_r;
  logic [SQ_W-1:0]         rad2_r;

  logic             sq_start, sq_sel_d2, sq_done, div_start, div_done, incircle, load;
  logic [SQ_W-1:0]  sq_val;
  logic [DIST_W-1:0] sq_root;
  logic [DIV_N-1:0] div_num, div_quo;
  logic [DIV_D-1:0] div_den;
  logic [41:0]      d2x25, r2x36;
  logic [OSUM_W-1:0] magx, magy;
  logic [COORD_W-1:0] axis_val;
  logic [32:0]      rad_prod;
  logic [PIX_W-1:0] rad_rem;

  function automatic logic [TOT_W-1:0] sat_tot(logic [TOT_W-1:0] a, logic [FLUX_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + (TOT_W+1)'(b);
    return s[TOT_W] ? '1 : s[TOT_W-1:0];
  endfunction

  function automatic logic signed [OSUM_W-1:0] sat_ofs(logic signed [OSUM_W-1:0] a,
                                                      logic signed [2*OFS_W-1:0] b);
    logic signed [OSUM_W:0] s;
    s = $signed({a[OSUM_W-1], a}) + (OSUM_W+1)'(b);
    if (s[OSUM_W] != s[OSUM_W-1])
      return s[OSUM_W] ? {1'b1, {(OSUM_W-1){1'b0}}} : {1'b0, {(OSUM_W-1){1'b1}}};
    return s[OSUM_W-1:0];
  endfunction

  // round-to-nearest quotient plus window edge, clamped to the output range
  function automatic logic [COORD_W-1:0] axis(logic neg, logic [DIV_N-1:0] q,
                                              logic [PIX_W-1:0] edge_px);
    logic signed [DIV_N+1:0] c;
    c = $signed({2'b00, q});
    if (neg) c = -c;
    c = c + $signed((DIV_N+2)'({edge_px, 8'h00}));
    if (c < 0) return '0;
    if (c > $signed((DIV_N+2)'(MAX24))) return MAX24;
    return c[COORD_W-1:0];
  endfunction

  // floor(72 * s^2 / 25) for the radius remainder s = r mod 25
  function automatic logic [10:0] rad_frac(logic [4:0] s);
    case (s)
      5'd0:    return 11'd0;
      5'd1:    return 11'd2;
      5'd2:    return 11'd11;
      5'd3:    return 11'd25;
      5'd4:    return 11'd46;
      5'd5:    return 11'd72;
      5'd6:    return 11'd103;
      5'd7:    return 11'd141;
      5'd8:    return 11'd184;
      5'd9:    return 11'd233;
      5'd10:   return 11'd288;
      5'd11:   return 11'd348;
      5'd12:   return 11'd414;
      5'd13:   return 11'd486;
      5'd14:   return 11'd564;
      5'd15:   return 11'd648;
      5'd16:   return 11'd737;
      5'd17:   return 11'd832;
      5'd18:   return 11'd933;
      5'd19:   return 11'd1039;
      5'd20:   return 11'd1152;
      5'd21:   return 11'd1270;
      5'd22:   return 11'd1393;
      5'd23:   return 11'd1523;
      5'd24:   return 11'd1658;
      default: return 11'd0;
    endcase
  endfunction

  shc_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .val(sq_val), .done(sq_done), .root(sq_root)
  );

  shc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  always_comb begin
    d2x25    = (42'(item_r.d2) << 4) + (42'(item_r.d2) << 3) + 42'(item_r.d2);
    r2x36    = (42'(r2_r) << 5) + (42'(r2_r) << 2);
    incircle = item_r.in_range && (d2x25 <= r2x36);
    magx     = sx_r[OSUM_W-1] ? OSUM_W'(-sx_r) : OSUM_W'(sx_r);
    magy     = sy_r[OSUM_W-1] ? OSUM_W'(-sy_r) : OSUM_W'(sy_r);
    sq_val   = sq_sel_d2 ? SQ_W'(item_r.d2) : rad2_r;
    axis_val = axis((op_r == OP_CX) ? sx_r[OSUM_W-1] : sy_r[OSUM_W-1], div_quo,
                    (op_r == OP_CX) ? cfg.window_x : cfg.window_y);
    load     = (state_r == B_EMIT) && (!out_valid_r || out_ready);
    // split r = 25q + s so that 2.88 r^2 = 1800 q^2 + 144 q s + 72 s^2 / 25
    rad_prod = 33'(cfg.star_radius) * RAD_RECIP;
    rad_rem  = rad_r - PIX_W'({rad_q_r, 4'b0000}) - PIX_W'({rad_q_r, 3'b000})
             - PIX_W'(rad_q_r);
  end

  always_comb begin
    div_num = '0;
    div_den = DIV_D'(cf_r);
    case (op_nxt)
      OP_HFR:  div_num = DIV_N'(wsum_r) + DIV_N'(cf_r >> 1);
      OP_CX:   div_num = DIV_N'({magx, 8'h00}) + DIV_N'(cf_r >> 1);
      OP_CY:   div_num = DIV_N'({magy, 8'h00}) + DIV_N'(cf_r >> 1);
      OP_MEAN: begin
        div_num = DIV_N'({total_r, 8'h00}) + DIV_N'(seen_r >> 1);
        div_den = DIV_D'(seen_r);
      end
      default: div_num = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    fifo_pop  = 1'b0;
    sq_start  = 1'b0;
    sq_sel_d2 = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      B_IDLE: if (!fifo_empty) begin
        fifo_pop  = 1'b1;
        state_nxt = B_CHECK;
      end
      B_CHECK: begin
        if (counted_r && incircle) begin
          sq_start  = 1'b1;
          sq_sel_d2 = 1'b1;
          state_nxt = B_SQRT;
        end else begin
          state_nxt = item_r.last ? B_FIN : B_IDLE;
        end
      end
      B_SQRT: if (sq_done) state_nxt = B_MUL;
      B_MUL:  state_nxt = B_ACC;
      B_ACC:  state_nxt = item_r.last ? B_FIN : B_IDLE;
      B_FIN: begin
        if (cf_r != '0) begin
          div_start = 1'b1;
          op_nxt    = OP_HFR;
          state_nxt = B_DIV;
        end else begin
          sq_start  = 1'b1;
          state_nxt = B_RSQRT;
        end
      end
      B_DIV: if (div_done) begin
        unique case (op_r)
          OP_HFR: begin
            div_start = 1'b1;
            op_nxt    = OP_CX;
          end
          OP_CX: begin
            div_start = 1'b1;
            op_nxt    = OP_CY;
          end
          OP_CY: begin
            if (seen_r != '0) begin
              div_start = 1'b1;
              op_nxt    = OP_MEAN;
            end else begin
              state_nxt = B_EMIT;
            end
          end
          OP_MEAN: state_nxt = B_EMIT;
          default: state_nxt = B_EMIT;
        endcase
      end
      B_RSQRT: if (sq_done) begin
        if (seen_r != '0) begin
          div_start = 1'b1;
          op_nxt    = OP_MEAN;
          state_nxt = B_DIV;
        end else begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: if (load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      op_r        <= OP_HFR;
      out_valid_r <= 1'b0;
      seen_r      <= '0;
      total_r     <= '0;
      cf_r        <= '0;
      wsum_r      <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        B_CHECK: if (counted_r) begin
          seen_r  <= seen_r + 1'b1;
          total_r <= sat_tot(total_r, item_r.flux);
        end
        B_ACC: begin
          cf_r <= sat_tot(cf_r, item_r.flux);
          if ({1'b0, wsum_r} + (WSUM_W+1)'(pd_r) > (WSUM_W+1)'({WSUM_W{1'b1}}))
            wsum_r <= '1;
          else
            wsum_r <= wsum_r + WSUM_W'(pd_r);
          sx_r <= sat_ofs(sx_r, px_r);
          sy_r <= sat_ofs(sy_r, py_r);
        end
        B_EMIT: if (load) begin
          seen_r  <= '0;
          total_r <= '0;
          cf_r    <= '0;
          wsum_r  <= '0;
          sx_r    <= '0;
          sy_r    <= '0;
        end
        default: ;
      endcase
    end

    r2_r <= cfg.star_radius * cfg.star_radius;
    // squared fallback radius, pipelined through registers after a radius write
    rad_r    <= cfg.star_radius;
    rad_q_r  <= rad_prod[32:21];
    rad_q2_r <= rad_q_r;
    rad_s_r  <= rad_rem[4:0];
    rad_qq_r <= rad_q2_r * rad_q2_r;
    rad_qs_r <= rad_q2_r * rad_s_r;
    rad_t_r  <= rad_frac(rad_s_r);
    rad2_r   <= (SQ_W'(rad_qq_r) << 10) + (SQ_W'(rad_qq_r) << 9) + (SQ_W'(rad_qq_r) << 8)
              + (SQ_W'(rad_qq_r) << 3) + (SQ_W'(rad_qs_r) << 7) + (SQ_W'(rad_qs_r) << 4)
              + SQ_W'(rad_t_r);
    if (state_r == B_IDLE && !fifo_empty) begin
      item_r    <= fifo_item;
      counted_r <= seen_r < SEEN_W'(MAX_PIXELS);
    end
    if (state_r == B_SQRT && sq_done) dist_r <= sq_root;
    if (state_r == B_MUL) begin
      pd_r <= item_r.flux * dist_r;
      px_r <= item_r.ofs_x * $signed({1'b0, item_r.flux});
      py_r <= item_r.ofs_y * $signed({1'b0, item_r.flux});
    end
    if (state_r == B_FIN) begin
      upd_r  <= (cf_r != '0);
      cxo_r  <= cfg.center_x;
      cyo_r  <= cfg.center_y;
      mean_r <= '0;
    end
    if (state_r == B_DIV && div_done) begin
      case (op_r)
        OP_HFR:  hfr_r  <= (div_quo > DIV_N'(MAX24)) ? MAX24 : div_quo[COORD_W-1:0];
        OP_CX:   cxo_r  <= axis_val;
        OP_CY:   cyo_r  <= axis_val;
        OP_MEAN: mean_r <= (div_quo > DIV_N'(MAX24)) ? MAX24 : div_quo[COORD_W-1:0];
        default: ;
      endcase
    end
    if (state_r == B_RSQRT && sq_done) hfr_r <= COORD_W'(sq_root);
    if (load) begin
      out_res_r.half_flux_radius <= hfr_r;
      out_res_r.mean_flux        <= mean_r;
      out_res_r.centroid_x       <= cxo_r;
      out_res_r.centroid_y       <= cyo_r;
      out_res_r.centroid_updated <= upd_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire

### rtl/star_hfr_centroid_core.sv
// Top level of the star half-flux-radius and centroid core.
`timescale 1ns / 1ps
`default_nettype none
// Takes the pixels of one star as a stream (x, y, value, tlast on the final
// pixel) and returns one result per star: half-flux radius, mean flux and the
// flux-weighted centroid, all Q16.8. A two-stage front end takes a pixel every
// cycle while the queue has room, subtracts the background and forms the
// squared distance to the configured centre; a four-deep queue hands pixels to
// the back end. The back end only tests a pixel outside 1.2x the radius; one
// inside it also goes through the 19-step iterative square root. After the
// last pixel the shared one-bit-per-cycle divider runs up to four divisions
// before the result appears; the input keeps filling the queue meanwhile.
// With no flux in the circle the radius is sqrt(2.88) times the star radius
// and the configured centre is returned with tuser low.
// Write configuration only while the core is idle.
module star_hfr_centroid_core #(
  parameter int MAX_PIXELS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // pixel_x, pixel_y, pixel_value
  input  wire logic        in_tlast,   // last_pixel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // half_flux_radius, mean_flux, centroid_x, centroid_y
  output logic             out_tuser,  // centroid_updated
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [23:0] cfg_wdata
);
  import shc_pkg::*;

  shc_cfg_t    cfg_r;
  shc_item_t   push_item, pop_item;
  shc_result_t res;
  logic        fifo_push, fifo_pop, fifo_empty;
  logic [LVL_W-1:0] fifo_level;

  // configuration registers; hold their value between writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_CENTER_X:   cfg_r.center_x        <= cfg_wdata;
        REG_CENTER_Y:   cfg_r.center_y        <= cfg_wdata;
        REG_WINDOW_X:   cfg_r.window_x        <= cfg_wdata[PIX_W-1:0];
        REG_WINDOW_Y:   cfg_r.window_y        <= cfg_wdata[PIX_W-1:0];
        REG_STAR_RAD:   cfg_r.star_radius     <= cfg_wdata[PIX_W-1:0];
        REG_BACKGROUND: cfg_r.background_mean <= cfg_wdata;
        default: ;
      endcase
    end
  end

  shc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .pixel_x(in_tdata[15:0]), .pixel_y(in_tdata[31:16]), .pixel_value(in_tdata[47:32]),
    .last_pixel(in_tlast), .cfg(cfg_r), .fifo_level(fifo_level),
    .push(fifo_push), .push_item(push_item)
  );

  shc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(fifo_push), .din(push_item),
    .pop(fifo_pop), .dout(pop_item), .empty(fifo_empty), .level(fifo_level)
  );

  shc_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .fifo_empty(fifo_empty), .fifo_pop(fifo_pop), .fifo_item(pop_item),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {res.centroid_y, res.centroid_x, res.mean_flux, res.half_flux_radius};
  assign out_tuser = res.centroid_updated;

  // queue never holds more than its depth
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_level <= LVL_W'(FIFO_DEPTH))
    else $error("queue level above depth");

  // credit check keeps a push from landing on a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_push && !fifo_pop && fifo_level == LVL_W'(FIFO_DEPTH)))
    else $error("push into full queue");

  // without an update the configured centre is passed through
  a_center_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |->
      (out_tdata[71:48] == cfg_r.center_x && out_tdata[95:72] == cfg_r.center_y))
    else $error("centre not kept on empty circle");

endmodule
`default_nettype wire

### tb/star_hfr_centroid_core_tb.sv
// Self-checking testbench for the star HFR / centroid core.
`timescale 1ns / 1ps
module star_hfr_centroid_core_tb;
  import shc_pkg::*;

  // A pixel as the sender queues it.
  typedef struct {
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pv;
    logic        last;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // pixel_x, pixel_y, pixel_value
  logic        in_tlast;   // last_pixel
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;  // half_flux_radius, mean_flux, centroid_x, centroid_y
  logic        out_tuser;  // centroid_updated
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [23:0] cfg_wdata;

  star_hfr_centroid_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Pixels waiting for the driver, star results waiting for the core.
  pixel_t      pending_pixels[$];
  shc_result_t star_results[$];

  // Predictor copy of the registers and the per-star sums.
  longint unsigned m_cx, m_cy, m_wx, m_wy, m_rad, m_bg;
  longint unsigned tot_flux, ring_flux, dist_sum;
  longint          ofs_x_sum, ofs_y_sum;
  int unsigned     pix_count;

  int  errors;
  bit  calm;        // no gaps on either side while set
  bit  in_fire;     // pixel transaction at the last rising edge
  int  in_gap;
  int  out_gap;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    #50_000_000;
    $display("star_hfr_centroid_core verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned add_sat_u(input longint unsigned a, b, lim);
    return (a + b > lim) ? lim : a + b;
  endfunction

  function automatic longint add_sat_s46(input longint a, b);
    longint s;
    s = a + b;
    if (s > (64'sd1 <<< 45) - 1) return (64'sd1 <<< 45) - 1;
    if (s < -(64'sd1 <<< 45)) return -(64'sd1 <<< 45);
    return s;
  endfunction

  function automatic longint unsigned clamp_coord(input longint v);
    if (v < 0) return 0;
    if (v > 64'hFFFFFF) return 64'hFFFFFF;
    return v;
  endfunction

  // Rounded flux-weighted mean offset plus the window edge, in Q.8.
  function automatic longint centroid_of(input longint sum, input longint unsigned edge_px);
    longint unsigned mag, q;
    mag = (sum < 0) ? -sum : sum;
    q   = ((mag << FRAC) + ring_flux / 2) / ring_flux;
    return ((sum < 0) ? -longint'(q) : longint'(q)) + longint'(edge_px << FRAC);
  endfunction

  // Accumulate one accepted pixel; on the last one, queue the star result.
  task automatic absorb_pixel(input logic [15:0] px, py, pv, input logic last);
    longint          diff, dx, dy;
    longint unsigned flux, ax, ay, d2, root_d, hfr, mean;
    shc_result_t     res;
    if (pix_count < 4096) begin
      diff = longint'({48'd0, pv} << FRAC) - longint'(m_bg);
      flux = (diff > 0) ? ((diff + 128) >> FRAC) : 0;
      pix_count++;
      tot_flux = add_sat_u(tot_flux, flux, 64'hFFFFFFF);
      dx = longint'({48'd0, px} << FRAC) - longint'(m_cx);
      dy = longint'({48'd0, py} << FRAC) - longint'(m_cy);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax < (64'd1 << 18) && ay < (64'd1 << 18)) begin
        d2 = ax * ax + ay * ay;
        if (25 * d2 <= 36 * m_rad * m_rad) begin
          root_d    = int_sqrt(d2);
          ring_flux = add_sat_u(ring_flux, flux, 64'hFFFFFFF);
          dist_sum  = add_sat_u(dist_sum, flux * root_d, (64'd1 << 53) - 1);
          ofs_x_sum = add_sat_s46(ofs_x_sum, (longint'(px) - longint'(m_wx)) * longint'(flux));
          ofs_y_sum = add_sat_s46(ofs_y_sum, (longint'(py) - longint'(m_wy)) * longint'(flux));
        end
      end
    end
    if (last) begin
      if (ring_flux > 0) begin
        hfr = (dist_sum + ring_flux / 2) / ring_flux;
        res.centroid_x       = 24'(clamp_coord(centroid_of(ofs_x_sum, m_wx)));
        res.centroid_y       = 24'(clamp_coord(centroid_of(ofs_y_sum, m_wy)));
        res.centroid_updated = 1'b1;
      end else begin
        hfr = int_sqrt((288 * m_rad * m_rad) / 100);
        res.centroid_x       = 24'(m_cx);
        res.centroid_y       = 24'(m_cy);
        res.centroid_updated = 1'b0;
      end
      mean = 0;
      if (pix_count > 0) mean = ((tot_flux << FRAC) + pix_count / 2) / pix_count;
      res.half_flux_radius = (hfr > 64'hFFFFFF) ? 24'hFFFFFF : 24'(hfr);
      res.mean_flux        = (mean > 64'hFFFFFF) ? 24'hFFFFFF : 24'(mean);
      star_results.push_back(res);
      tot_flux = 0; ring_flux = 0; dist_sum = 0;
      ofs_x_sum = 0; ofs_y_sum = 0; pix_count = 0;
    end
  endtask

  task automatic report(input string what, input longint unsigned got, want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  // Monitor: check results against the oldest expectation, then predict.
  always @(posedge clk) begin
    shc_result_t want;
    in_fire <= in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (star_results.size() == 0) begin
        report("unexpected result", out_tdata[23:0], 0);
      end else begin
        want = star_results.pop_front();
        if (out_tdata[23:0] !== want.half_flux_radius)
          report("half_flux_radius", out_tdata[23:0], want.half_flux_radius);
        if (out_tdata[47:24] !== want.mean_flux)
          report("mean_flux", out_tdata[47:24], want.mean_flux);
        if (out_tdata[71:48] !== want.centroid_x)
          report("centroid_x", out_tdata[71:48], want.centroid_x);
        if (out_tdata[95:72] !== want.centroid_y)
          report("centroid_y", out_tdata[95:72], want.centroid_y);
        if (out_tuser !== want.centroid_updated)
          report("centroid_updated", out_tuser, want.centroid_updated);
      end
    end
    if (rst_n && in_tvalid && in_tready)
      absorb_pixel(in_tdata[15:0], in_tdata[31:16], in_tdata[47:32], in_tlast);
  end

  // Pixel driver: hold an offered pixel until taken, then gap or send the next.
  always @(negedge clk) begin
    pixel_t p;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else if (in_tvalid && !in_fire) begin
      // hold
    end else if (in_gap > 0) begin
      in_gap    <= in_gap - 1;
      in_tvalid <= 1'b0;
    end else if (pending_pixels.size() > 0) begin
      p = pending_pixels.pop_front();
      in_tdata  <= {p.pv, p.py, p.px};
      in_tlast  <= p.last;
      in_tvalid <= 1'b1;
      in_gap    <= pick_gap();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result sink: stall at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else if (out_gap > 0) begin
      out_gap    <= out_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_gap    <= pick_gap();
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input longint unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= 24'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Write all six registers and mirror them, cut to register width.
  task automatic set_config(input longint unsigned cx, cy, wx, wy, rad, bg);
    write_reg(REG_CENTER_X, cx);   m_cx  = cx & 64'hFFFFFF;
    write_reg(REG_CENTER_Y, cy);   m_cy  = cy & 64'hFFFFFF;
    write_reg(REG_WINDOW_X, wx);   m_wx  = wx & 64'hFFFF;
    write_reg(REG_WINDOW_Y, wy);   m_wy  = wy & 64'hFFFF;
    write_reg(REG_STAR_RAD, rad);  m_rad = rad & 64'hFFFF;
    write_reg(REG_BACKGROUND, bg); m_bg  = bg & 64'hFFFFFF;
  endtask

  task automatic add_pixel(input logic [15:0] px, py, pv, input logic last);
    pixel_t p;
    p.px = px; p.py = py; p.pv = pv; p.last = last;
    pending_pixels.push_back(p);
  endtask

  // Drain everything, then give the back end time to finish any pixel still
  // in flight so the next register write lands on an idle core.
  task automatic drain();
    while (pending_pixels.size() > 0 || star_results.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // One random star around the configured centre, some pixels scattered wide.
  task automatic random_star(input int npix);
    int k, r;
    logic [15:0] px, py, pv;
    for (k = 0; k < npix; k++) begin
      r  = $urandom_range(0, 99);
      px = 16'((m_cx >> FRAC) + $urandom_range(0, 24) - 12);
      py = 16'((m_cy >> FRAC) + $urandom_range(0, 24) - 12);
      if (r < 8) begin
        px = 16'($urandom); py = 16'($urandom);
      end
      r  = $urandom_range(0, 99);
      if (r < 25) pv = 16'($urandom);
      else if (r < 35) pv = 0;
      else pv = 16'((m_bg >> FRAC) + $urandom_range(0, 3000) - 500);
      add_pixel(px, py, pv, k == npix - 1);
    end
  endtask

  task automatic random_config();
    longint unsigned wx, wy;
    wx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 65535);
    wy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 65535);
    set_config(((wx + $urandom_range(0, 30)) << FRAC) + $urandom_range(0, 255) & 24'hFFFFFF,
               ((wy + $urandom_range(0, 30)) << FRAC) + $urandom_range(0, 255) & 24'hFFFFFF,
               wx, wy,
               ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 16 << FRAC),
               ($urandom_range(0, 4) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                           : $urandom_range(0, 2000 << FRAC));
  endtask

  initial begin
    int sent, k;
    errors = 0; calm = 0;
    tot_flux = 0; ring_flux = 0; dist_sum = 0;
    ofs_x_sum = 0; ofs_y_sum = 0; pix_count = 0;
    m_cx = 0; m_cy = 0; m_wx = 0; m_wy = 0; m_rad = 0; m_bg = 0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_addr = REG_CENTER_X; cfg_wdata = '0;
    in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0; out_tready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Reset configuration: zero radius, so only a pixel on the centre counts.
    add_pixel(16'd0, 16'd0, 16'hFFFF, 1'b1);
    add_pixel(16'd1, 16'd0, 16'hFFFF, 1'b1);
    add_pixel(16'hFFFF, 16'hFFFF, 16'd0, 1'b1);
    drain();

    // No flux at all: background above every pixel.
    set_config(24'h001000, 24'h001000, 16'd0, 16'd0, 16'h0400, 24'hFFFFFF);
    add_pixel(16'h10, 16'h10, 16'hFFFF, 1'b0);
    add_pixel(16'h11, 16'h10, 16'h0000, 1'b1);
    drain();

    // Rounding at exactly half, pixels left of and above the window.
    set_config(24'h000280, 24'h000280, 16'd5, 16'd5, 16'h0500, 24'h000080);
    add_pixel(16'd2, 16'd2, 16'd1, 1'b0);
    add_pixel(16'd0, 16'd3, 16'd200, 1'b0);
    add_pixel(16'd3, 16'd0, 16'hFFFF, 1'b1);
    drain();

    // Extremes: centre, window and radius at their maximum, background zero.
    set_config(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd0);
    add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_pixel(16'hFF00, 16'hFFF0, 16'h8000, 1'b0);
    add_pixel(16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    drain();

    // Radius edge: pixel exactly at 1.2x the radius and one just beyond.
    set_config(24'h000A00, 24'h000A00, 16'd0, 16'd0, 16'h0500, 24'd0);
    add_pixel(16'd16, 16'd10, 16'd100, 1'b0);
    add_pixel(16'd17, 16'd10, 16'd100, 1'b1);
    drain();

    // Random stars; each phase ends idle, so the sender pauses for results.
    sent = 0;
    while (sent < 2000) begin
      random_config();
      calm = ($urandom_range(0, 4) == 0);
      for (k = 0; k < 6; k++) begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
        random_star(n);
        sent += n;
      end
      drain();
    end

    if (errors == 0) begin
      $display("star_hfr_centroid_core verification clean");
    end else begin
      $display("star_hfr_centroid_core verification failed");
    end
    $finish;
  end

endmodule

### star_hfr_centroid_core.f
rtl/shc_pkg.sv
rtl/shc_front.sv
rtl/shc_fifo.sv
rtl/shc_sqrt.sv
rtl/shc_div.sv
rtl/shc_back.sv
rtl/star_hfr_centroid_core.sv
tb/star_hfr_centroid_core_tb.sv
